/* rtl/voxel_owner_map_window_query_defines.svh */
// assertion macros for the voxel owner map block
`ifndef VOXEL_OWNER_MAP_WINDOW_QUERY_DEFINES_SVH
`define VOXEL_OWNER_MAP_WINDOW_QUERY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VOMQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vomq: same-cycle check failed");
`define VOMQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vomq: next-cycle check failed");
`else
`define VOMQ_ASSERT_IMP(lbl, ante, cons)
`define VOMQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/vomq_pkg.sv */
package vomq_pkg;

    localparam int DIM_MAX    = 16;
    localparam int MAX_OWNERS = 64;
    localparam int RADIUS_MAX = 3;

    localparam int CELL_W  = 6;
    localparam int OWN_W   = 7;
    localparam int OP_W    = 3;
    localparam int SIZE_W  = 5;
    localparam int RFLD_W  = 2;
    localparam int CFG_AW  = 2;
    localparam int SIZE_RST = 16;

    localparam int MAP_DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int DIM_W     = $clog2(DIM_MAX);
    localparam int SZ_W      = $clog2(DIM_MAX + 1);
    localparam int RAD_W     = $clog2(RADIUS_MAX + 1);
    localparam int OFF_W     = RAD_W + 1;
    localparam int CRD_W     = ((CELL_W > OFF_W) ? CELL_W : OFF_W) + 1;
    localparam int CMP_W     = (CRD_W > SZ_W) ? CRD_W : SZ_W;

    localparam int GRP_SZ = 8;
    localparam int SUB_W  = $clog2(GRP_SZ);
    localparam int NGRP   = (MAX_OWNERS + GRP_SZ - 1) / GRP_SZ;
    localparam int MASK_W = NGRP * GRP_SZ;
    localparam int IDX_W  = $clog2(MASK_W);
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;

    // input tdata layout
    localparam int CX_LSB    = 0;
    localparam int CY_LSB    = CX_LSB + CELL_W;
    localparam int CZ_LSB    = CY_LSB + CELL_W;
    localparam int PROC_LSB  = CZ_LSB + CELL_W;
    localparam int RAD_LSB   = PROC_LSB + OWN_W;
    localparam int S_FLD_W   = RAD_LSB + RFLD_W;
    localparam int S_TDATA_W = ((S_FLD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OWN_W + 7) / 8) * 8;

    localparam logic [OWN_W-1:0] UNOWNED = '1;

    localparam logic [OP_W-1:0] OP_WRITE      = 3'd0;
    localparam logic [OP_W-1:0] OP_READ       = 3'd1;
    localparam logic [OP_W-1:0] OP_NEAR_EDGE  = 3'd2;
    localparam logic [OP_W-1:0] OP_NEAR_OWNER = 3'd3;
    localparam logic [OP_W-1:0] OP_NEAR_OTHER = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST       = 3'd5;

    localparam logic [CFG_AW-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_AW-1:0] REG_SIZE_Z = 2'd2;

    typedef struct packed {
        logic              valid;
        logic              in_grid;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } scan_pos_t;

    typedef struct packed {
        logic             valid;
        logic [OWN_W-1:0] owner;
        logic             last;
    } lst_item_t;

    function automatic logic [SZ_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return SZ_W'(1);
        end else if (int'(s) > DIM_MAX) begin
            return SZ_W'(DIM_MAX);
        end
        return SZ_W'(s);
    endfunction

    function automatic logic coord_inside(input logic signed [CRD_W-1:0] c,
                                          input logic [SZ_W-1:0] n);
        logic [CMP_W-1:0] cu;
        cu = CMP_W'(c[CRD_W-2:0]);
        return !c[CRD_W-1] && (cu < CMP_W'(n));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
                                                    input logic signed [CRD_W-1:0] y,
                                                    input logic signed [CRD_W-1:0] z);
        return ADDR_W'(x[DIM_W-1:0]) + ADDR_W'(DIM_MAX) *
               (ADDR_W'(y[DIM_W-1:0]) + ADDR_W'(DIM_MAX) * ADDR_W'(z[DIM_W-1:0]));
    endfunction

endpackage

/* rtl/voxel_owner_map_window_query.sv */
// voxel owner map with window queries
//
// s_ channel: one transaction per operation, op in s_tuser. write gives no
// result, read and the three near-queries give one result, list gives one
// result per distinct owner found, ascending, with m_tlast on the final one
// (or a single value -1, flag 0 result when none is found).
// cfg port: cfg_we writes size_x, size_y or size_z at index cfg_addr; write
// only while the block is idle.
// write goes to the map ram as it is accepted. read and window queries walk
// the window one position per cycle, reading in-grid cells through the single
// read port of the map ram, then pass a drain step before the result step.
// list replaces the result step by a list step that sends the owners one by
// one, stepping through the owner mask in groups of 8 owners.
// one operation is in flight at a time; the next is taken when it finishes.
// reset: the map is cleared by a pass over all 4096 entries, one entry per cycle;
// s_tready stays low during the pass. sizes reset to 16.
// stall: results sit in an output register; a stalled m_ side holds the
// block in its result or list step, and a new transaction can be taken while the
// final result still waits.
`include "voxel_owner_map_window_query_defines.svh"

module voxel_owner_map_window_query import vomq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cell_x, cell_y, cell_z, proc, window_radius
    input  logic [OP_W-1:0]      s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // value
    output logic [0:0]           m_tuser,   // flag
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [SIZE_W-1:0]    cfg_wdata
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_RESULT = 6'b010000,
        ST_LIST   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [SZ_W-1:0]   nx, ny, nz;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic signed [CELL_W-1:0] f_cx, f_cy, f_cz;
    logic [OWN_W-1:0]         f_proc;
    logic [RFLD_W-1:0]        f_rad;
    logic [OP_W-1:0]          f_op;
    logic [RAD_W-1:0]         rad_eff;
    logic signed [CRD_W-1:0]  ex, ey, ez;
    logic                     cell_in, interior;

    logic             accept, is_scan_op, scan_start;
    logic [OP_W-1:0]  op_reg;
    logic [OWN_W-1:0] proc_reg, val_reg;
    logic             hit_reg;

    scan_pos_t         pos;
    logic              s1_valid_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [OWN_W-1:0]  ram_wdata, rd_data;

    lst_item_t        item;
    logic             lst_any, lst_take;

    logic             out_free, out_load, m_tvalid_reg;
    logic [OWN_W-1:0] out_value_reg, out_value;
    logic             out_flag_reg, out_flag, out_last_reg, out_last;

    // field unpacking
    assign f_op   = s_tuser;
    assign f_cx   = s_tdata[CX_LSB +: CELL_W];
    assign f_cy   = s_tdata[CY_LSB +: CELL_W];
    assign f_cz   = s_tdata[CZ_LSB +: CELL_W];
    assign f_proc = s_tdata[PROC_LSB +: OWN_W];
    assign f_rad  = s_tdata[RAD_LSB +: RFLD_W];

    assign nx = eff_size(size_x_reg);
    assign ny = eff_size(size_y_reg);
    assign nz = eff_size(size_z_reg);

    assign ex = CRD_W'(f_cx);
    assign ey = CRD_W'(f_cy);
    assign ez = CRD_W'(f_cz);

    assign cell_in  = coord_inside(ex, nx) && coord_inside(ey, ny) && coord_inside(ez, nz);
    assign interior = coord_inside(ex - CRD_W'(1), nx) && coord_inside(ex + CRD_W'(1), nx) &&
                      coord_inside(ey - CRD_W'(1), ny) && coord_inside(ey + CRD_W'(1), ny) &&
                      coord_inside(ez - CRD_W'(1), nz) && coord_inside(ez + CRD_W'(1), nz);

    assign rad_eff = (int'(f_rad) > RADIUS_MAX) ? RAD_W'(RADIUS_MAX) : RAD_W'(f_rad);

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign is_scan_op = (f_op == OP_READ) || (f_op == OP_NEAR_EDGE) ||
                        (f_op == OP_NEAR_OWNER) || (f_op == OP_NEAR_OTHER) ||
                        (f_op == OP_LIST);
    assign scan_start = accept && is_scan_op;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_W'(SIZE_RST);
            size_y_reg <= SIZE_W'(SIZE_RST);
            size_z_reg <= SIZE_W'(SIZE_RST);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SIZE_X: size_x_reg <= cfg_wdata;
                REG_SIZE_Y: size_y_reg <= cfg_wdata;
                REG_SIZE_Z: size_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // map ram, write port shared by clearing pass and owner writes
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = UNOWNED;
        end else begin
            ram_we    = accept && (f_op == OP_WRITE) && cell_in;
            ram_waddr = cell_addr(ex, ey, ez);
            ram_wdata = f_proc;
        end
    end

    vomq_ram #(
        .WIDTH (OWN_W),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pos.valid && pos.in_grid),
        .raddr (pos.addr),
        .rdata (rd_data)
    );

    vomq_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .cell_x  (f_cx),
        .cell_y  (f_cy),
        .cell_z  (f_cz),
        .radius  ((f_op == OP_READ) ? RAD_W'(0) : rad_eff),
        .nx      (nx),
        .ny      (ny),
        .nz      (nz),
        .pos     (pos)
    );

    vomq_list u_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (accept && (f_op == OP_LIST)),
        .set_en  (s1_valid_reg && (op_reg == OP_LIST)),
        .set_idx (rd_data),
        .run     (state_reg == ST_LIST),
        .take    (lst_take),
        .item    (item),
        .any     (lst_any)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s1_valid_reg <= pos.valid && pos.in_grid;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    // per-operation accumulators, updated from read data
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= f_op;
            proc_reg <= f_proc;
            hit_reg  <= (f_op == OP_NEAR_EDGE) && !interior;
            val_reg  <= UNOWNED;
        end else if (s1_valid_reg) begin
            unique case (op_reg)
                OP_READ: begin
                    val_reg <= rd_data;
                    hit_reg <= 1'b1;
                end
                OP_NEAR_EDGE: begin
                    if (rd_data == UNOWNED) hit_reg <= 1'b1;
                end
                OP_NEAR_OWNER: begin
                    if (rd_data == proc_reg) hit_reg <= 1'b1;
                end
                OP_NEAR_OTHER: begin
                    if (rd_data != proc_reg && rd_data != UNOWNED) hit_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign lst_take = (state_reg == ST_LIST) && out_free && item.valid;

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        out_value  = UNOWNED;
        out_flag   = 1'b0;
        out_last   = 1'b1;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == ADDR_W'(MAP_DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (scan_start) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (pos.valid && pos.last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = (op_reg == OP_LIST) ? ST_LIST : ST_RESULT;
            end
            ST_RESULT: begin
                out_load  = out_free;
                out_value = (op_reg == OP_READ) ? val_reg : UNOWNED;
                out_flag  = hit_reg;
                if (out_free) state_next = ST_IDLE;
            end
            ST_LIST: begin
                if (!lst_any) begin
                    out_load = out_free;
                    if (out_free) state_next = ST_IDLE;
                end else begin
                    out_load  = lst_take;
                    out_value = item.owner;
                    out_flag  = 1'b1;
                    out_last  = item.last;
                    if (lst_take && item.last) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_value_reg <= out_value;
            out_flag_reg  <= out_flag;
            out_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_value_reg);
    assign m_tuser  = out_flag_reg;
    assign m_tlast  = out_last_reg;

    `VOMQ_ASSERT_IMP(a_no_write_in_scan, ram_we, state_reg == ST_CLEAR || state_reg == ST_IDLE)
    `VOMQ_ASSERT_IMP(a_scan_only_in_scan, pos.valid, state_reg == ST_SCAN)
    `VOMQ_ASSERT_NXT(a_drain_exit, state_reg == ST_DRAIN, state_reg == ST_RESULT || state_reg == ST_LIST)
    `VOMQ_ASSERT_IMP(a_no_load_over_held, out_load, !m_tvalid || m_tready)

endmodule

/* rtl/vomq_ram.sv */
module vomq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vomq_scan.sv */
module vomq_scan import vomq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [CELL_W-1:0] cell_x,
    input  logic signed [CELL_W-1:0] cell_y,
    input  logic signed [CELL_W-1:0] cell_z,
    input  logic [RAD_W-1:0]         radius,
    input  logic [SZ_W-1:0]          nx,
    input  logic [SZ_W-1:0]          ny,
    input  logic [SZ_W-1:0]          nz,
    output scan_pos_t                pos
);

    logic                     active_reg;
    logic signed [CELL_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [OFF_W-1:0]  rad_reg, dx_reg, dy_reg, dz_reg;
    logic signed [OFF_W-1:0]  rad_in;
    logic signed [CRD_W-1:0]  x, y, z;
    logic                     end_x, end_y, end_z;

    assign rad_in = signed'({1'b0, radius});

    assign x = CRD_W'(cx_reg) + CRD_W'(dx_reg);
    assign y = CRD_W'(cy_reg) + CRD_W'(dy_reg);
    assign z = CRD_W'(cz_reg) + CRD_W'(dz_reg);

    assign end_x = (dx_reg == rad_reg);
    assign end_y = (dy_reg == rad_reg);
    assign end_z = (dz_reg == rad_reg);

    always_comb begin
        pos.valid   = active_reg;
        pos.in_grid = coord_inside(x, nx) && coord_inside(y, ny) && coord_inside(z, nz);
        pos.addr    = cell_addr(x, y, z);
        pos.last    = end_x && end_y && end_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (start) begin
            active_reg <= 1'b1;
        end else if (active_reg && pos.last) begin
            active_reg <= 1'b0;
        end
    end

    // window walk, z fastest
    always_ff @(posedge aclk) begin
        if (start) begin
            cx_reg  <= cell_x;
            cy_reg  <= cell_y;
            cz_reg  <= cell_z;
            rad_reg <= rad_in;
            dx_reg  <= -rad_in;
            dy_reg  <= -rad_in;
            dz_reg  <= -rad_in;
        end else if (active_reg) begin
            if (!end_z) begin
                dz_reg <= dz_reg + OFF_W'(1);
            end else begin
                dz_reg <= -rad_reg;
                if (!end_y) begin
                    dy_reg <= dy_reg + OFF_W'(1);
                end else begin
                    dy_reg <= -rad_reg;
                    dx_reg <= dx_reg + OFF_W'(1);
                end
            end
        end
    end

endmodule

/* rtl/vomq_list.sv */
module vomq_list import vomq_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr,
    input  logic             set_en,
    input  logic [OWN_W-1:0] set_idx,
    input  logic             run,
    input  logic             take,
    output lst_item_t        item,
    output logic             any
);

    logic [MASK_W-1:0] mask_reg;
    logic [GRP_W-1:0]  grp_reg;
    logic [GRP_SZ-1:0] cur;
    logic [SUB_W-1:0]  sub;
    logic [IDX_W-1:0]  bit_idx;
    logic [MASK_W-1:0] rest;

    always_comb begin
        cur = mask_reg[IDX_W'({grp_reg, SUB_W'(0)}) +: GRP_SZ];
        sub = '0;
        for (int i = GRP_SZ - 1; i >= 0; i--) begin
            if (cur[i]) begin
                sub = SUB_W'(i);
            end
        end
        bit_idx = IDX_W'({grp_reg, sub});
        rest = mask_reg;
        rest[bit_idx] = 1'b0;
        item.valid = |cur;
        item.owner = OWN_W'(bit_idx);
        item.last  = ~|rest;
        any = |mask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            mask_reg <= '0;
            grp_reg  <= '0;
        end else if (set_en && (int'(set_idx) < MAX_OWNERS)) begin
            mask_reg[set_idx[IDX_W-1:0]] <= 1'b1;
        end else if (take) begin
            mask_reg <= rest;
        end else if (run && any && (cur == '0)) begin
            grp_reg <= grp_reg + GRP_W'(1);
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import vomq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int TAIL_CYCLES = 500;
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic signed [CELL_W-1:0] cz;
        logic [OWN_W-1:0]         proc;
        logic [RFLD_W-1:0]        rad;
    } map_cmd_t;

    typedef struct {
        logic [OWN_W-1:0] value;
        logic             flag;
        logic             last;
    } owner_answer_t;

    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_SLOW} rdy_pattern_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // cell_x, cell_y, cell_z, proc, window_radius
    logic [OP_W-1:0]      s_tuser = '0;   // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;        // value
    logic [0:0]           m_tuser;        // flag
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;

    logic [OWN_W-1:0]  owner_shadow [MAP_DEPTH];
    logic [SIZE_W-1:0] size_shadow [3];
    owner_answer_t     pending_answers [$];

    int           mismatches = 0;
    int           cycles = 0;
    int           burst_left = 0;
    int           hold_left = 0;
    int           ready_seg = 0;
    rdy_pattern_t ready_mode = RDY_ALWAYS;
    bit           steady_feed = 1'b0;

    voxel_owner_map_window_query dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int active_cells(input logic [SIZE_W-1:0] s);
        if (s == 0) begin
            return 1;
        end
        if (s > DIM_MAX) begin
            return DIM_MAX;
        end
        return int'(s);
    endfunction

    function automatic bit in_grid(input int x, input int y, input int z);
        return x >= 0 && x < active_cells(size_shadow[0]) &&
               y >= 0 && y < active_cells(size_shadow[1]) &&
               z >= 0 && z < active_cells(size_shadow[2]);
    endfunction

    function automatic int map_index(input int x, input int y, input int z);
        return x + DIM_MAX * (y + DIM_MAX * z);
    endfunction

    // expected results of one operation, and the map update for writes
    function automatic void answer_cmd(input map_cmd_t c);
        int cx, cy, cz, nx, ny, nz, r, x, y, z, o;
        bit hit, found;
        logic [MAX_OWNERS-1:0] seen;
        logic [OWN_W-1:0] v;
        cx = c.cx;
        cy = c.cy;
        cz = c.cz;
        nx = active_cells(size_shadow[0]);
        ny = active_cells(size_shadow[1]);
        nz = active_cells(size_shadow[2]);
        r = c.rad;
        hit = 1'b0;
        found = 1'b0;
        seen = '0;
        if (c.op == OP_WRITE) begin
            if (in_grid(cx, cy, cz)) begin
                owner_shadow[map_index(cx, cy, cz)] = c.proc;
            end
        end else if (c.op == OP_READ) begin
            if (in_grid(cx, cy, cz)) begin
                pending_answers.push_back('{owner_shadow[map_index(cx, cy, cz)], 1'b1, 1'b1});
            end else begin
                pending_answers.push_back('{UNOWNED, 1'b0, 1'b1});
            end
        end else if (c.op == OP_NEAR_EDGE || c.op == OP_NEAR_OWNER ||
                     c.op == OP_NEAR_OTHER || c.op == OP_LIST) begin
            if (c.op == OP_NEAR_EDGE) begin
                hit = !(cx >= 1 && cx < nx - 1 && cy >= 1 && cy < ny - 1 &&
                        cz >= 1 && cz < nz - 1);
            end
            for (int dx = -r; dx <= r; dx++) begin
                for (int dy = -r; dy <= r; dy++) begin
                    for (int dz = -r; dz <= r; dz++) begin
                        x = cx + dx;
                        y = cy + dy;
                        z = cz + dz;
                        if (in_grid(x, y, z)) begin
                            v = owner_shadow[map_index(x, y, z)];
                            case (c.op)
                                OP_NEAR_EDGE: begin
                                    if (v == UNOWNED) hit = 1'b1;
                                end
                                OP_NEAR_OWNER: begin
                                    if (v == c.proc) hit = 1'b1;
                                end
                                OP_NEAR_OTHER: begin
                                    if (v != c.proc && v != UNOWNED) hit = 1'b1;
                                end
                                default: begin
                                    if (v < MAX_OWNERS) seen[v] = 1'b1;
                                end
                            endcase
                        end
                    end
                end
            end
            if (c.op != OP_LIST) begin
                pending_answers.push_back('{UNOWNED, hit, 1'b1});
            end else begin
                for (o = 0; o < MAX_OWNERS; o++) begin
                    if (seen[o]) begin
                        pending_answers.push_back('{OWN_W'(o), 1'b1, 1'b0});
                        found = 1'b1;
                    end
                end
                if (found) begin
                    pending_answers[pending_answers.size() - 1].last = 1'b1;
                end else begin
                    pending_answers.push_back('{UNOWNED, 1'b0, 1'b1});
                end
            end
        end
    endfunction

    function automatic map_cmd_t mk_cmd(input logic [OP_W-1:0] op, input int x, input int y,
                                        input int z, input int owner, input int rad);
        map_cmd_t c;
        c.op = op;
        c.cx = CELL_W'(x);
        c.cy = CELL_W'(y);
        c.cz = CELL_W'(z);
        c.proc = OWN_W'(owner);
        c.rad = RFLD_W'(rad);
        return c;
    endfunction

    // mostly just around the grid, sometimes anywhere in the field range
    function automatic int random_coord(input int n);
        if ($urandom_range(0, 6) == 0) begin
            return int'($urandom_range(0, 63)) - 32;
        end
        return int'($urandom_range(0, n + 1)) - 1;
    endfunction

    function automatic int random_owner();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            return $urandom_range(0, 5);
        end else if (pick < 16) begin
            return -1;
        end else if (pick < 18) begin
            return $urandom_range(0, 63);
        end
        return int'($urandom_range(0, 127)) - 64;
    endfunction

    function automatic map_cmd_t random_cmd();
        map_cmd_t c;
        int pick;
        logic [OP_W-1:0] op;
        int rad;
        pick = $urandom_range(0, 99);
        if (pick < 30) op = OP_WRITE;
        else if (pick < 40) op = OP_READ;
        else if (pick < 52) op = OP_NEAR_EDGE;
        else if (pick < 64) op = OP_NEAR_OWNER;
        else if (pick < 76) op = OP_NEAR_OTHER;
        else if (pick < 96) op = OP_LIST;
        else if (pick < 98) op = OP_SPARE_A;
        else op = OP_SPARE_B;
        pick = $urandom_range(0, 19);
        rad = (pick < 5) ? 0 : (pick < 14) ? 1 : (pick < 18) ? 2 : 3;
        c = mk_cmd(op, random_coord(active_cells(size_shadow[0])),
                   random_coord(active_cells(size_shadow[1])),
                   random_coord(active_cells(size_shadow[2])), random_owner(), rad);
        return c;
    endfunction

    task automatic send_cmd(input map_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && !steady_feed) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'({c.rad, c.proc, c.cz, c.cy, c.cx});
        s_tuser <= c.op;
        do @(posedge aclk); while (!s_tready);
        answer_cmd(c);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        size_shadow[idx] = val;
    endtask

    task automatic set_sizes(input int sx, input int sy, input int sz);
        wait_idle();
        write_reg(REG_SIZE_X, SIZE_W'(sx));
        write_reg(REG_SIZE_Y, SIZE_W'(sy));
        write_reg(REG_SIZE_Z, SIZE_W'(sz));
    endtask

    task automatic run_random(input int n);
        map_cmd_t c;
        int done;
        done = 0;
        while (done < n) begin
            c = random_cmd();
            send_cmd(c);
            if (c.op <= OP_LIST) done++;
        end
    endtask

    task automatic test_directed();
        send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_READ, -1, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_READ, 31, -32, 5, 63, 3));
        send_cmd(mk_cmd(OP_WRITE, 0, 0, 0, 5, 0));
        send_cmd(mk_cmd(OP_WRITE, 15, 15, 15, 63, 0));
        send_cmd(mk_cmd(OP_WRITE, 16, 0, 0, 9, 0));
        send_cmd(mk_cmd(OP_WRITE, -32, -32, -32, 9, 0));
        send_cmd(mk_cmd(OP_READ, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_READ, 15, 15, 15, 0, 0));
        send_cmd(mk_cmd(OP_READ, 16, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_NEAR_EDGE, 8, 8, 8, 0, 0));
        send_cmd(mk_cmd(OP_WRITE, 8, 8, 8, 0, 0));
        send_cmd(mk_cmd(OP_NEAR_EDGE, 8, 8, 8, 0, 0));
        send_cmd(mk_cmd(OP_NEAR_EDGE, 8, 8, 8, 0, 1));
        send_cmd(mk_cmd(OP_NEAR_EDGE, 0, 0, 0, 0, 0));
        send_cmd(mk_cmd(OP_NEAR_OWNER, 8, 8, 8, 0, 1));
        send_cmd(mk_cmd(OP_NEAR_OWNER, 8, 8, 8, 1, 1));
        send_cmd(mk_cmd(OP_NEAR_OWNER, 3, 3, 3, -1, 2));
        send_cmd(mk_cmd(OP_WRITE, 9, 8, 8, 1, 0));
        send_cmd(mk_cmd(OP_NEAR_OTHER, 8, 8, 8, 0, 0));
        send_cmd(mk_cmd(OP_NEAR_OTHER, 8, 8, 8, 0, 1));
        // stored values outside the owner range are never listed
        send_cmd(mk_cmd(OP_WRITE, 7, 8, 8, -64, 0));
        send_cmd(mk_cmd(OP_LIST, 8, 8, 8, 0, 1));
        send_cmd(mk_cmd(OP_LIST, 3, 3, 12, 0, 0));
        send_cmd(mk_cmd(OP_LIST, 15, 15, 15, 0, 3));
        send_cmd(mk_cmd(OP_SPARE_A, 8, 8, 8, 2, 1));
        send_cmd(mk_cmd(OP_SPARE_B, 8, 8, 8, 2, 1));
        send_cmd(mk_cmd(OP_WRITE, 8, 8, 8, -1, 0));
        send_cmd(mk_cmd(OP_READ, 8, 8, 8, 0, 0));
    endtask

    // every owner id in one radius-3 window, then random traffic around it
    task automatic test_dense_owners();
        int i, pick;
        set_sizes(DIM_MAX, DIM_MAX, DIM_MAX);
        for (i = 0; i < MAX_OWNERS; i++) begin
            send_cmd(mk_cmd(OP_WRITE, 5 + i % 7, 5 + (i / 7) % 7, 5 + i / 49, i, 0));
        end
        send_cmd(mk_cmd(OP_LIST, 8, 8, 8, 0, 3));
        for (i = 0; i < 80; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_cmd(mk_cmd(OP_WRITE, $urandom_range(5, 11), $urandom_range(5, 11),
                                $urandom_range(5, 11),
                                ($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 63), 0));
            end else begin
                send_cmd(mk_cmd((pick < 8) ? OP_LIST :
                                ($urandom_range(0, 1) == 0) ? OP_NEAR_OWNER : OP_NEAR_OTHER,
                                $urandom_range(7, 9), $urandom_range(7, 9),
                                $urandom_range(7, 9), $urandom_range(0, 63),
                                $urandom_range(2, 3)));
            end
        end
    endtask

    task automatic test_size_sweep();
        set_sizes(0, 1, 31);
        run_random(40);
        set_sizes(17, 2, 5);
        run_random(40);
        set_sizes(3, 4, 1);
        run_random(40);
        set_sizes(1, 16, 2);
        run_random(40);
        set_sizes($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
        run_random(40);
        set_sizes(4, 4, 4);
        run_random(40);
    endtask

    task automatic test_backpressure();
        map_cmd_t c;
        int i;
        wait_idle();
        steady_feed = 1'b1;
        hold_left = 700;
        for (i = 0; i < 40; i++) begin
            c = random_cmd();
            c.rad = RFLD_W'($urandom_range(0, 1));
            send_cmd(c);
        end
        steady_feed = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (ready_seg == 0) begin
                ready_mode = rdy_pattern_t'($urandom_range(0, 3));
                ready_seg = $urandom_range(4, 90);
            end
            ready_seg--;
            case (ready_mode)
                RDY_ALWAYS: m_tready <= 1'b1;
                RDY_HALF: m_tready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        owner_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                $display("%0t unexpected transaction: expected none, actual value %0d flag %0b last %0b",
                         $time, $signed(m_tdata[OWN_W-1:0]), m_tuser, m_tlast);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata !== M_TDATA_W'(want.value)) begin
                    mismatches++;
                    $display("%0t value mismatch: expected %0d, actual %0d (tdata %h)", $time,
                             $signed(want.value), $signed(m_tdata[OWN_W-1:0]), m_tdata);
                end
                if (m_tuser[0] !== want.flag) begin
                    mismatches++;
                    $display("%0t flag mismatch: expected %0b, actual %0b", $time, want.flag,
                             m_tuser[0]);
                end
                if (m_tlast !== want.last) begin
                    mismatches++;
                    $display("%0t last mismatch: expected %0b, actual %0b", $time, want.last,
                             m_tlast);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < MAP_DEPTH; i++) begin
            owner_shadow[i] = UNOWNED;
        end
        for (int i = 0; i < 3; i++) begin
            size_shadow[i] = SIZE_W'(SIZE_RST);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_dense_owners();
        test_size_sweep();
        test_backpressure();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
